// ===== hw/rtl/arp_pkg.sv =====
package arp_pkg;

    // frame layout
    localparam logic [5:0] FRAME_LEN = 6'd42;

    // fixed header values of an arp frame for ipv4 over ethernet
    localparam logic [15:0] ETH_TYPE_ARP = 16'h0806;
    localparam logic [15:0] HTYPE_ETH    = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4   = 16'h0800;
    localparam logic [7:0]  HLEN_MAC     = 8'd6;
    localparam logic [7:0]  PLEN_IPV4    = 8'd4;
    localparam logic [15:0] OP_REQUEST   = 16'h0001;
    localparam logic [15:0] OP_REPLY     = 16'h0002;

    // configuration register indexes
    localparam logic CFG_OWN_MAC = 1'b0;
    localparam logic CFG_OWN_IP  = 1'b1;

    // status codes of a result item
    typedef enum logic [2:0] {
        ST_NOT_ARP     = 3'd0,
        ST_BAD_HDR     = 3'd1,
        ST_REQ_OTHER   = 3'd2,
        ST_REPLIED     = 3'd3,
        ST_REPLY_OTHER = 3'd4,
        ST_CACHED      = 3'd5,
        ST_OTHER_OP    = 3'd6,
        ST_SHORT       = 3'd7
    } t_status;

    // byte of the arp reply frame at a given position
    function automatic logic [7:0] reply_byte(
        input logic [5:0]  pos,
        input logic [47:0] peer_mac,
        input logic [47:0] own_mac,
        input logic [31:0] own_ip,
        input logic [31:0] peer_ip
    );
        logic [7:0] b;
        b = 8'h00;
        case (pos) inside
            [6'd0:6'd5]:   b = peer_mac[8*(5 - int'(pos)) +: 8];
            [6'd6:6'd11]:  b = own_mac[8*(11 - int'(pos)) +: 8];
            6'd12:         b = ETH_TYPE_ARP[15:8];
            6'd13:         b = ETH_TYPE_ARP[7:0];
            6'd14:         b = HTYPE_ETH[15:8];
            6'd15:         b = HTYPE_ETH[7:0];
            6'd16:         b = PTYPE_IPV4[15:8];
            6'd17:         b = PTYPE_IPV4[7:0];
            6'd18:         b = HLEN_MAC;
            6'd19:         b = PLEN_IPV4;
            6'd20:         b = OP_REPLY[15:8];
            6'd21:         b = OP_REPLY[7:0];
            [6'd22:6'd27]: b = own_mac[8*(27 - int'(pos)) +: 8];
            [6'd28:6'd31]: b = own_ip[8*(31 - int'(pos)) +: 8];
            [6'd32:6'd37]: b = peer_mac[8*(37 - int'(pos)) +: 8];
            [6'd38:6'd41]: b = peer_ip[8*(41 - int'(pos)) +: 8];
            default:       b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/arp_responder_core.sv =====
// a status item is registered once the last frame byte is taken; the first reply
//   byte passes the reply generator, then the output register; one frame byte per
//   cycle in; a reply streams 42 items, one per cycle unless the output stalls, while
//   the next frame is taken; a last byte waits until the reply is out
// reset: synchronous, active low; clears own_mac, own_ip, cache, byte count, header flag
module arp_responder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [47:0] i_cfg_data,
    // received frame bytes
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic        i_s_tlast,   // rx_last
    // result items
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [87:0] o_m_tdata,   // [7:0] tx_byte, [39:8] cache_ip, [87:40] cache_mac
    output logic [3:0]  o_m_tuser,   // [2:0] status, [3] cache_valid
    output logic        o_m_tlast    // tx_last
);

    // configuration
    logic [47:0] r_own_mac;
    logic [31:0] r_own_ip;

    // frame capture
    logic [5:0]  r_byte_count, n_byte_count;
    logic [47:0] r_peer_mac, n_peer_mac;
    logic [15:0] r_eth_type, n_eth_type;
    logic        r_header_ok, n_header_ok;
    logic [15:0] r_opcode, n_opcode;
    logic [47:0] r_sender_mac, n_sender_mac;
    logic [31:0] r_sender_ip, n_sender_ip;
    logic [47:0] r_target_mac, n_target_mac;
    logic [31:0] r_target_ip, n_target_ip;

    // one-entry cache
    logic [31:0] r_entry_ip;
    logic [47:0] r_entry_mac;
    logic        r_entry_written;

    // reply generator
    logic        r_tx_active;
    logic [5:0]  r_tx_pos;
    logic [47:0] r_rep_peer;
    logic [31:0] r_rep_sip;

    // output register
    logic        r_out_valid;
    arp_pkg::t_status r_out_status;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic        r_out_cvalid;
    logic [31:0] r_out_cip;
    logic [47:0] r_out_cmac;

    logic             out_free;
    logic             s_fire;
    logic             frame_end;
    logic             gen_load;
    logic             cache_load;
    arp_pkg::t_status status;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_m_tready;
    // a last byte is held while a reply is still streaming or the output is full
    assign o_s_tready  = !i_s_tlast || (!r_tx_active && out_free);
    assign s_fire      = i_s_tvalid && o_s_tready;
    assign frame_end   = s_fire && i_s_tlast;
    assign gen_load    = r_tx_active && out_free;
    assign cache_load  = frame_end && (status == arp_pkg::ST_CACHED);

    // capture of the incoming byte by position
    always_comb begin
        n_byte_count = r_byte_count;
        n_peer_mac   = r_peer_mac;
        n_eth_type   = r_eth_type;
        n_header_ok  = r_header_ok;
        n_opcode     = r_opcode;
        n_sender_mac = r_sender_mac;
        n_sender_ip  = r_sender_ip;
        n_target_mac = r_target_mac;
        n_target_ip  = r_target_ip;
        if (r_byte_count < arp_pkg::FRAME_LEN) begin
            n_byte_count = r_byte_count + 6'd1;
            case (r_byte_count) inside
                [6'd6:6'd11]:  n_peer_mac = {r_peer_mac[39:0], i_s_tdata};
                [6'd12:6'd13]: n_eth_type = {r_eth_type[7:0], i_s_tdata};
                6'd14: begin
                    if (i_s_tdata != arp_pkg::HTYPE_ETH[15:8]) n_header_ok = 1'b0;
                end
                6'd15: begin
                    if (i_s_tdata != arp_pkg::HTYPE_ETH[7:0]) n_header_ok = 1'b0;
                end
                6'd16: begin
                    if (i_s_tdata != arp_pkg::PTYPE_IPV4[15:8]) n_header_ok = 1'b0;
                end
                6'd17: begin
                    if (i_s_tdata != arp_pkg::PTYPE_IPV4[7:0]) n_header_ok = 1'b0;
                end
                6'd18: begin
                    if (i_s_tdata != arp_pkg::HLEN_MAC) n_header_ok = 1'b0;
                end
                6'd19: begin
                    if (i_s_tdata != arp_pkg::PLEN_IPV4) n_header_ok = 1'b0;
                end
                [6'd20:6'd21]: n_opcode     = {r_opcode[7:0], i_s_tdata};
                [6'd22:6'd27]: n_sender_mac = {r_sender_mac[39:0], i_s_tdata};
                [6'd28:6'd31]: n_sender_ip  = {r_sender_ip[23:0], i_s_tdata};
                [6'd32:6'd37]: n_target_mac = {r_target_mac[39:0], i_s_tdata};
                [6'd38:6'd41]: n_target_ip  = {r_target_ip[23:0], i_s_tdata};
                default: ;
            endcase
        end
    end

    // frame verdict, checked in order: length, ethertype, header, opcode
    always_comb begin
        if (n_byte_count < arp_pkg::FRAME_LEN) begin
            status = arp_pkg::ST_SHORT;
        end else if (n_eth_type != arp_pkg::ETH_TYPE_ARP) begin
            status = arp_pkg::ST_NOT_ARP;
        end else if (!n_header_ok) begin
            status = arp_pkg::ST_BAD_HDR;
        end else if (n_opcode == arp_pkg::OP_REQUEST) begin
            status = (n_target_ip == r_own_ip) ? arp_pkg::ST_REPLIED : arp_pkg::ST_REQ_OTHER;
        end else if (n_opcode == arp_pkg::OP_REPLY) begin
            status = (n_target_mac == r_own_mac) ? arp_pkg::ST_CACHED
                                                 : arp_pkg::ST_REPLY_OTHER;
        end else begin
            status = arp_pkg::ST_OTHER_OP;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac       <= '0;
            r_own_ip        <= '0;
            r_byte_count    <= '0;
            r_header_ok     <= 1'b1;
            r_entry_ip      <= '0;
            r_entry_mac     <= '0;
            r_entry_written <= 1'b0;
            r_tx_active     <= 1'b0;
            r_tx_pos        <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_valid) begin
                if (i_cfg_index == arp_pkg::CFG_OWN_MAC) r_own_mac <= i_cfg_data;
                else                                     r_own_ip  <= i_cfg_data[31:0];
            end
            // byte count and header flag restart after each frame
            if (s_fire) begin
                r_byte_count <= frame_end ? 6'd0 : n_byte_count;
                r_header_ok  <= frame_end ? 1'b1 : n_header_ok;
            end
            // cache update
            if (cache_load) begin
                r_entry_ip      <= n_sender_ip;
                r_entry_mac     <= n_sender_mac;
                r_entry_written <= 1'b1;
            end
            // reply generator
            if (frame_end && status == arp_pkg::ST_REPLIED) begin
                r_tx_active <= 1'b1;
                r_tx_pos    <= '0;
            end else if (gen_load) begin
                r_tx_pos <= r_tx_pos + 6'd1;
                if (r_tx_pos == arp_pkg::FRAME_LEN - 6'd1) r_tx_active <= 1'b0;
            end
            // output valid
            if (gen_load || (frame_end && status != arp_pkg::ST_REPLIED)) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_peer_mac   <= n_peer_mac;
            r_eth_type   <= n_eth_type;
            r_opcode     <= n_opcode;
            r_sender_mac <= n_sender_mac;
            r_sender_ip  <= n_sender_ip;
            r_target_mac <= n_target_mac;
            r_target_ip  <= n_target_ip;
        end
        // reply fields held while the reply streams out
        if (frame_end && status == arp_pkg::ST_REPLIED) begin
            r_rep_peer <= n_peer_mac;
            r_rep_sip  <= n_sender_ip;
        end
        if (gen_load) begin
            r_out_status <= arp_pkg::ST_REPLIED;
            r_out_byte   <= arp_pkg::reply_byte(r_tx_pos, r_rep_peer, r_own_mac,
                                                r_own_ip, r_rep_sip);
            r_out_last   <= (r_tx_pos == arp_pkg::FRAME_LEN - 6'd1);
            r_out_cvalid <= r_entry_written;
            r_out_cip    <= r_entry_ip;
            r_out_cmac   <= r_entry_mac;
        end else if (frame_end && status != arp_pkg::ST_REPLIED) begin
            r_out_status <= status;
            r_out_byte   <= 8'h00;
            r_out_last   <= 1'b1;
            r_out_cvalid <= cache_load ? 1'b1 : r_entry_written;
            r_out_cip    <= cache_load ? n_sender_ip : r_entry_ip;
            r_out_cmac   <= cache_load ? n_sender_mac : r_entry_mac;
        end
    end

    // output ports
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_cmac, r_out_cip, r_out_byte};
    assign o_m_tuser  = {r_out_cvalid, r_out_status};
    assign o_m_tlast  = r_out_last;

    // checks
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_active |-> (r_tx_pos < arp_pkg::FRAME_LEN))
        else $error("reply position out of range");

    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= arp_pkg::FRAME_LEN)
        else $error("byte count beyond frame length");

    a_no_end_in_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |-> !r_tx_active)
        else $error("frame end taken while reply streams");

    a_reply_ends_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_tx_active) |-> (r_out_valid && r_out_last))
        else $error("reply ended without a last item");

endmodule

// ===== tb/tb_arp_responder_core.sv =====
module tb_arp_responder_core;

    localparam int WATCHDOG_LIMIT = 500;
    localparam int DRAIN_CYCLES   = 8;
    localparam int ITEM_TARGET    = 300;
    localparam int REPORT_MAX     = 10;

    // one result item as the block presents it
    typedef struct packed {
        arp_pkg::t_status status;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic        cache_valid;
        logic [31:0] cache_ip;
        logic [47:0] cache_mac;
    } t_arp_result;

    typedef enum int {
        FK_REQ_OURS,
        FK_REQ_OTHER,
        FK_REPLY_OURS,
        FK_REPLY_OTHER,
        FK_OTHER_OP,
        FK_BAD_HDR,
        FK_NOT_ARP,
        FK_NOISE,
        FK_ZEROS,
        FK_ONES
    } t_frame_kind;

    // arp responder predictor and result checker
    class t_arp_scoreboard;
        logic [47:0] own_mac;
        logic [31:0] own_ip;
        int          byte_pos;
        logic [47:0] peer_mac;
        logic [15:0] eth_type;
        logic        hdr_ok;
        logic [15:0] opcode;
        logic [47:0] snd_mac;
        logic [31:0] snd_ip;
        logic [47:0] tgt_mac;
        logic [31:0] tgt_ip;
        logic        entry_valid;
        logic [31:0] entry_ip;
        logic [47:0] entry_mac;
        t_arp_result pending_q[$];
        int          mismatches;
        int          results_seen;
        int          status_hits[8];

        function new();
            own_mac     = '0;
            own_ip      = '0;
            entry_valid = 1'b0;
            entry_ip    = '0;
            entry_mac   = '0;
            mismatches  = 0;
            results_seen = 0;
            foreach (status_hits[i]) status_hits[i] = 0;
            clear_capture();
        endfunction

        function void clear_capture();
            byte_pos = 0;
            peer_mac = '0;
            eth_type = '0;
            hdr_ok   = 1'b1;
            opcode   = '0;
            snd_mac  = '0;
            snd_ip   = '0;
            tgt_mac  = '0;
            tgt_ip   = '0;
        endfunction

        function void set_reg(logic idx, logic [47:0] value);
            if (idx == arp_pkg::CFG_OWN_MAC) begin
                own_mac = value;
            end else begin
                own_ip = value[31:0];
            end
        endfunction

        // capture one frame byte; on the last byte queue the items it causes
        function void note_byte(logic [7:0] b, logic last);
            arp_pkg::t_status st;
            logic [335:0] reply;
            t_arp_result  r;
            if (byte_pos < int'(arp_pkg::FRAME_LEN)) begin
                if (byte_pos >= 6 && byte_pos < 12) peer_mac = {peer_mac[39:0], b};
                else if (byte_pos == 12 || byte_pos == 13) eth_type = {eth_type[7:0], b};
                else if (byte_pos == 14) hdr_ok &= (b == arp_pkg::HTYPE_ETH[15:8]);
                else if (byte_pos == 15) hdr_ok &= (b == arp_pkg::HTYPE_ETH[7:0]);
                else if (byte_pos == 16) hdr_ok &= (b == arp_pkg::PTYPE_IPV4[15:8]);
                else if (byte_pos == 17) hdr_ok &= (b == arp_pkg::PTYPE_IPV4[7:0]);
                else if (byte_pos == 18) hdr_ok &= (b == arp_pkg::HLEN_MAC);
                else if (byte_pos == 19) hdr_ok &= (b == arp_pkg::PLEN_IPV4);
                else if (byte_pos == 20 || byte_pos == 21) opcode = {opcode[7:0], b};
                else if (byte_pos >= 22 && byte_pos < 28) snd_mac = {snd_mac[39:0], b};
                else if (byte_pos >= 28 && byte_pos < 32) snd_ip = {snd_ip[23:0], b};
                else if (byte_pos >= 32 && byte_pos < 38) tgt_mac = {tgt_mac[39:0], b};
                else if (byte_pos >= 38) tgt_ip = {tgt_ip[23:0], b};
                byte_pos++;
            end
            if (!last) return;

            // checks in order: length, ethertype, header, opcode
            if (byte_pos < int'(arp_pkg::FRAME_LEN)) st = arp_pkg::ST_SHORT;
            else if (eth_type != arp_pkg::ETH_TYPE_ARP) st = arp_pkg::ST_NOT_ARP;
            else if (!hdr_ok) st = arp_pkg::ST_BAD_HDR;
            else if (opcode == arp_pkg::OP_REQUEST) begin
                st = (tgt_ip == own_ip) ? arp_pkg::ST_REPLIED : arp_pkg::ST_REQ_OTHER;
            end else if (opcode == arp_pkg::OP_REPLY) begin
                if (tgt_mac == own_mac) begin
                    entry_valid = 1'b1;
                    entry_ip    = snd_ip;
                    entry_mac   = snd_mac;
                    st = arp_pkg::ST_CACHED;
                end else begin
                    st = arp_pkg::ST_REPLY_OTHER;
                end
            end else st = arp_pkg::ST_OTHER_OP;
            status_hits[st]++;

            r.status      = st;
            r.cache_valid = entry_valid;
            r.cache_ip    = entry_ip;
            r.cache_mac   = entry_mac;
            if (st == arp_pkg::ST_REPLIED) begin
                // reply frame laid out first byte in the top bits
                reply = {peer_mac, own_mac, arp_pkg::ETH_TYPE_ARP, arp_pkg::HTYPE_ETH,
                         arp_pkg::PTYPE_IPV4, arp_pkg::HLEN_MAC, arp_pkg::PLEN_IPV4,
                         arp_pkg::OP_REPLY, own_mac, own_ip, peer_mac, snd_ip};
                for (int k = 0; k < int'(arp_pkg::FRAME_LEN); k++) begin
                    r.tx_byte = reply[335 - 8*k -: 8];
                    r.tx_last = (k == int'(arp_pkg::FRAME_LEN) - 1);
                    pending_q.push_back(r);
                end
            end else begin
                r.tx_byte = 8'h00;
                r.tx_last = 1'b1;
                pending_q.push_back(r);
            end
            clear_capture();
        endfunction

        // compare one accepted result item with the oldest expected one
        function void check_result(logic [87:0] data, logic [3:0] user, logic last);
            t_arp_result got;
            t_arp_result want;
            got.status      = arp_pkg::t_status'(user[2:0]);
            got.cache_valid = user[3];
            got.tx_byte     = data[7:0];
            got.cache_ip    = data[39:8];
            got.cache_mac   = data[87:40];
            got.tx_last     = last;
            results_seen++;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result item: status %0d tx %02h last %0d",
                             got.status, got.tx_byte, got.tx_last);
                return;
            end
            want = pending_q.pop_front();
            if (got.status !== want.status || got.tx_byte !== want.tx_byte ||
                got.tx_last !== want.tx_last || got.cache_valid !== want.cache_valid ||
                got.cache_ip !== want.cache_ip || got.cache_mac !== want.cache_mac) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display({"mismatch (exp/act): status %0d/%0d tx %02h/%02h last %0d/%0d ",
                              "valid %0d/%0d ip %08h/%08h mac %012h/%012h"},
                             want.status, got.status, want.tx_byte, got.tx_byte,
                             want.tx_last, got.tx_last, want.cache_valid, got.cache_valid,
                             want.cache_ip, got.cache_ip, want.cache_mac, got.cache_mac);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [47:0] i_cfg_data = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [87:0] o_m_tdata;
    logic [3:0]  o_m_tuser;
    logic        o_m_tlast;

    t_arp_scoreboard board = new();
    logic [7:0]    frame_q[$];
    bit            sender_idle = 1'b0;
    bit            recv_idle = 1'b0;
    int            rx_stall = 0;
    int            quiet_cycles = 0;
    int            bytes_sent = 0;
    int            frames_sent = 0;
    int            settings_used = 1;

    arp_responder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // result side: check accepted items and draw the stall before the next one
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            board.check_result(o_m_tdata, o_m_tuser, o_m_tlast);
            rx_stall = recv_idle ? $urandom_range(0, 5) : 0;
        end
    end

    always @(negedge i_clk) begin
        if (rx_stall > 0) begin
            i_m_tready <= 1'b0;
            rx_stall--;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [47:0] rand48();
        logic [47:0] v;
        v = {16'($urandom), 32'($urandom)};
        return v;
    endfunction

    // fill frame_q with a frame of the given kind; len > 0 trims or pads it
    function automatic void build_frame(t_frame_kind kind, int len);
        logic [335:0] f;
        logic [47:0]  dst, src, smac, tmac;
        logic [31:0]  sip, tip;
        logic [15:0]  etype, op;
        int           idx;
        dst   = $urandom_range(0, 1) ? 48'hFFFF_FFFF_FFFF : rand48();
        src   = rand48();
        smac  = $urandom_range(0, 3) == 0 ? rand48() : src;
        sip   = $urandom;
        tmac  = $urandom_range(0, 1) ? 48'h0 : rand48();
        tip   = $urandom;
        etype = arp_pkg::ETH_TYPE_ARP;
        op    = $urandom_range(0, 1) ? arp_pkg::OP_REQUEST : arp_pkg::OP_REPLY;
        case (kind)
            FK_REQ_OURS: begin
                op  = arp_pkg::OP_REQUEST;
                tip = board.own_ip;
            end
            FK_REQ_OTHER: begin
                op = arp_pkg::OP_REQUEST;
                if (tip == board.own_ip) tip = tip ^ 32'h1;
            end
            FK_REPLY_OURS: begin
                op   = arp_pkg::OP_REPLY;
                tmac = board.own_mac;
            end
            FK_REPLY_OTHER: begin
                op = arp_pkg::OP_REPLY;
                if (tmac == board.own_mac) tmac = tmac ^ 48'h1;
            end
            FK_OTHER_OP: begin
                op = $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom);
                if (op == arp_pkg::OP_REQUEST || op == arp_pkg::OP_REPLY) op = 16'h0000;
            end
            FK_NOT_ARP: begin
                etype = 16'($urandom);
                if (etype == arp_pkg::ETH_TYPE_ARP) etype = arp_pkg::PTYPE_IPV4;
            end
            default: ;
        endcase
        f = {dst, src, etype, arp_pkg::HTYPE_ETH, arp_pkg::PTYPE_IPV4, arp_pkg::HLEN_MAC,
             arp_pkg::PLEN_IPV4, op, smac, sip, tmac, tip};
        frame_q.delete();
        for (int i = 0; i < int'(arp_pkg::FRAME_LEN); i++) begin
            case (kind)
                FK_NOISE: frame_q.push_back(8'($urandom));
                FK_ZEROS: frame_q.push_back(8'h00);
                FK_ONES:  frame_q.push_back(8'hFF);
                default:  frame_q.push_back(f[335 - 8*i -: 8]);
            endcase
        end
        // spoil one fixed header byte
        if (kind == FK_BAD_HDR) begin
            idx = $urandom_range(14, 19);
            frame_q[idx] = frame_q[idx] ^ 8'($urandom_range(1, 255));
        end
        if (len > 0) begin
            while (frame_q.size() > len) void'(frame_q.pop_back());
            while (frame_q.size() < len)
                frame_q.push_back(kind == FK_ONES ? 8'hFF : 8'($urandom));
        end
    endfunction

    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        gap = sender_idle ? $urandom_range(0, 5) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        bytes_sent++;
        board.note_byte(b, last);
    endtask

    task automatic send_frame(t_frame_kind kind, int len);
        build_frame(kind, len);
        foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
        frames_sent++;
    endtask

    // stop sending and let every expected item come out
    task automatic wait_drained();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (board.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [47:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic reconfigure(logic [47:0] mac, logic [31:0] ip);
        wait_drained();
        write_reg(arp_pkg::CFG_OWN_MAC, mac);
        write_reg(arp_pkg::CFG_OWN_IP, {16'h0, ip});
        settings_used++;
    endtask

    // stimulus
    initial begin
        int          rand_frames;
        int          phase;
        int          pick;
        logic [47:0] mac;
        logic [31:0] ip;
        t_frame_kind kind;
        int          len;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extreme bytes, single-byte frames, reset addresses
        send_frame(FK_ONES, 1);
        send_frame(FK_ZEROS, 1);
        send_frame(FK_REQ_OURS, 42);

        // directed: all-ones addresses, a long frame and a short noisy one
        reconfigure(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_frame(FK_REPLY_OURS, 50);
        send_frame(FK_NOISE, 20);

        // random frames, mostly well formed, under changing addresses and idling
        rand_frames = 0;
        phase = 0;
        while (bytes_sent < ITEM_TARGET) begin
            if (rand_frames % 2 == 0) begin
                case (phase % 4)
                    1:       begin mac = 48'h0; ip = 32'h0; end
                    2:       begin mac = 48'hFFFF_FFFF_FFFF; ip = 32'hFFFF_FFFF; end
                    default: begin mac = rand48(); ip = $urandom; end
                endcase
                reconfigure(mac, ip);
                pick = (phase == 0) ? 3 : $urandom_range(0, 3);
                sender_idle = pick[0];
                recv_idle   = pick[1];
                phase++;
            end
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 4) == 0) ? $urandom_range(43, 60) : 42;
            if (pick < 25) kind = FK_REQ_OURS;
            else if (pick < 40) kind = FK_REPLY_OURS;
            else if (pick < 50) kind = FK_REQ_OTHER;
            else if (pick < 60) kind = FK_REPLY_OTHER;
            else if (pick < 68) kind = FK_OTHER_OP;
            else if (pick < 76) kind = FK_BAD_HDR;
            else if (pick < 84) kind = FK_NOT_ARP;
            else if (pick < 92) begin
                kind = $urandom_range(0, 1) ? FK_REQ_OURS : FK_REPLY_OURS;
                len  = $urandom_range(1, 41);
            end else begin
                kind = FK_NOISE;
                len  = $urandom_range(1, 64);
            end
            send_frame(kind, len);
            rand_frames++;
        end

        wait_drained();

        $display("covered %0d frames, %0d frame bytes, %0d address settings, %0d result items",
                 frames_sent, bytes_sent, settings_used, board.results_seen);
        $display({"outcomes: not-arp %0d bad-hdr %0d req-other %0d replied %0d ",
                  "reply-other %0d cached %0d other-op %0d short %0d"},
                 board.status_hits[arp_pkg::ST_NOT_ARP],
                 board.status_hits[arp_pkg::ST_BAD_HDR],
                 board.status_hits[arp_pkg::ST_REQ_OTHER],
                 board.status_hits[arp_pkg::ST_REPLIED],
                 board.status_hits[arp_pkg::ST_REPLY_OTHER],
                 board.status_hits[arp_pkg::ST_CACHED],
                 board.status_hits[arp_pkg::ST_OTHER_OP],
                 board.status_hits[arp_pkg::ST_SHORT]);
        if (board.pending_q.size() != 0)
            $display("%0d expected result items never arrived", board.pending_q.size());
        if (board.mismatches == 0 && board.pending_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", board.mismatches);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/arp_pkg.sv
hw/rtl/arp_responder_core.sv
tb/tb_arp_responder_core.sv
